### src/quat_scale_translate_point_defines.svh
// Assertion macros for the quat_scale_translate_point checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef QUAT_SCALE_TRANSLATE_POINT_DEFINES_SVH
`define QUAT_SCALE_TRANSLATE_POINT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define QSTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define QSTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/qstp_pkg.sv
// Shared types, register indexes and constants for the point transform.
// No dependencies; imported by every module of the block.
package qstp_pkg;

	localparam int PIPE_DEPTH = 7;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
	localparam int IDX_W      = 4;

	// register indexes on the config port
	localparam logic [IDX_W-1:0] REG_ROT_W   = 4'd0;
	localparam logic [IDX_W-1:0] REG_ROT_X   = 4'd1;
	localparam logic [IDX_W-1:0] REG_ROT_Y   = 4'd2;
	localparam logic [IDX_W-1:0] REG_ROT_Z   = 4'd3;
	localparam logic [IDX_W-1:0] REG_SCALE   = 4'd4;
	localparam logic [IDX_W-1:0] REG_SHIFT_X = 4'd5;
	localparam logic [IDX_W-1:0] REG_SHIFT_Y = 4'd6;
	localparam logic [IDX_W-1:0] REG_SHIFT_Z = 4'd7;

	localparam logic [15:0] ROT_W_RST = 16'h4000;
	localparam logic [47:0] SCALE_RST = 48'h1000_1000_1000;

	typedef logic signed [15:0] q214_t;   // Q2.14 and Q4.12 factors
	typedef logic signed [31:0] coord_t;  // Q16.16
	typedef logic signed [47:0] prod48_t; // coord * scale
	typedef logic signed [35:0] pval_t;   // scaled coordinate
	typedef logic signed [51:0] prod52_t; // q * p
	typedef logic signed [38:0] cval_t;   // first cross product, Q16.16
	typedef logic signed [54:0] prod55_t; // q * c, w * c
	typedef logic signed [58:0] rsum_t;   // Q.30 sum, half LSB added

	localparam logic signed [45:0] SAT_HI = 46'sd2147483647;
	localparam logic signed [45:0] SAT_LO = -46'sd2147483648;

	typedef struct packed {
		q214_t w;
		q214_t x;
		q214_t y;
		q214_t z;
	} quat_t;

	typedef struct packed {
		q214_t x;
		q214_t y;
		q214_t z;
	} scale_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} shift_t;

	typedef struct packed {
		logic  op;
		pval_t x;
		pval_t y;
		pval_t z;
	} scaled_t;

	typedef struct packed {
		logic  op;
		rsum_t x;
		rsum_t y;
		rsum_t z;
	} rot_t;

endpackage

### src/quat_scale_translate_point.sv
// Top level of the scale / quaternion rotate / translate point transform.
// Depends on qstp_pkg, qstp_scale, qstp_rotate and qstp_out.
//
// Usage:
//  - s_axis: one word per point. tdata = {in_z, in_y, in_x}, x in bits 31:0,
//    all signed Q16.16. tuser = op: 1 adds the translation (point),
//    0 leaves it out (direction).
//  - m_axis: one word per input word, same order. tdata = {out_z, out_y, out_x},
//    tuser = clipped, set when any coordinate hit the 32-bit limits.
//  - cfg: write-only register port, taken every cycle (cfg_ready is tied high).
//    Index 0..3 rotation w,x,y,z (Q2.14), 4 packed scale x,y,z (Q4.12),
//    5..7 translation x,y,z (Q16.16). Other indexes are dropped.
//    Write only while no word is in flight.
//  - Pipeline: seven register stages from acceptance to the word on m_axis
//    (scale multiply, scale round, q x p multiply, round, q x c / w*c
//    multiply, sum, translate and saturate).
//  - Throughput: one word per clock while m_axis_tready is high; each stage has
//    its own valid bit and loads whenever it is empty or the stage after it moves.
//  - Stall: with m_axis_tready low, words keep entering until every stage
//    holds one; then s_axis_tready drops. Nothing is dropped or repeated.
//  - Reset: all stages empty, rotation = identity, scale = 1.0, shift = 0.
module quat_scale_translate_point
	import qstp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [95:0]      s_axis_tdata,  // in_x [31:0], in_y [63:32], in_z [95:64]
	input  logic             s_axis_tuser,  // op [0]
	// output stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [95:0]      m_axis_tdata,  // out_x [31:0], out_y [63:32], out_z [95:64]
	output logic             m_axis_tuser,  // clipped [0]
	// register writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [47:0]      cfg_data
);

	// configuration registers
	q214_t  rot_w_q, rot_x_q, rot_y_q, rot_z_q;
	logic [47:0] scale_q;
	coord_t shift_x_q, shift_y_q, shift_z_q;

	quat_t   quat;
	scale_t  scale;
	shift_t  shift;

	logic    sc_valid, sc_ready;
	scaled_t sc_data;
	logic    rt_valid, rt_ready;
	rot_t    rt_data;
	coord_t  res_x, res_y, res_z;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w_q   <= ROT_W_RST;
			rot_x_q   <= '0;
			rot_y_q   <= '0;
			rot_z_q   <= '0;
			scale_q   <= SCALE_RST;
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROT_W:   rot_w_q   <= cfg_data[15:0];
				REG_ROT_X:   rot_x_q   <= cfg_data[15:0];
				REG_ROT_Y:   rot_y_q   <= cfg_data[15:0];
				REG_ROT_Z:   rot_z_q   <= cfg_data[15:0];
				REG_SCALE:   scale_q   <= cfg_data;
				REG_SHIFT_X: shift_x_q <= cfg_data[31:0];
				REG_SHIFT_Y: shift_y_q <= cfg_data[31:0];
				REG_SHIFT_Z: shift_z_q <= cfg_data[31:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign quat  = '{w: rot_w_q, x: rot_x_q, y: rot_y_q, z: rot_z_q};
	assign scale = '{x: scale_q[15:0], y: scale_q[31:16], z: scale_q[47:32]};
	assign shift = '{x: shift_x_q, y: shift_y_q, z: shift_z_q};

	// stages 1-2
	qstp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_x      (s_axis_tdata[31:0]),
		.in_y      (s_axis_tdata[63:32]),
		.in_z      (s_axis_tdata[95:64]),
		.scale     (scale),
		.out_valid (sc_valid),
		.out_ready (sc_ready),
		.out_data  (sc_data)
	);

	// stages 3-6
	qstp_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.in_ready  (sc_ready),
		.in_data   (sc_data),
		.quat      (quat),
		.out_valid (rt_valid),
		.out_ready (rt_ready),
		.out_data  (rt_data)
	);

	// stage 7, output register
	qstp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rt_valid),
		.in_ready    (rt_ready),
		.in_data     (rt_data),
		.shift       (shift),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_x       (res_x),
		.out_y       (res_y),
		.out_z       (res_z),
		.out_clipped (m_axis_tuser)
	);

	assign m_axis_tdata = {res_z, res_y, res_x};

endmodule

### src/qstp_scale.sv
// Scale stages: per-axis multiply by Q4.12 factors, then round to Q16.16.
// Depends on qstp_pkg.
module qstp_scale
	import qstp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    in_op,
	input  coord_t  in_x,
	input  coord_t  in_y,
	input  coord_t  in_z,
	input  scale_t  scale,
	output logic    out_valid,
	input  logic    out_ready,
	output scaled_t out_data
);

	logic    v_s1, v_s2;
	logic    en1, en2;
	logic    op_s1;
	prod48_t mx_s1, my_s1, mz_s1;
	prod48_t rx, ry, rz;
	scaled_t d_s2;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			op_s1 <= in_op;
			mx_s1 <= in_x * scale.x;
			my_s1 <= in_y * scale.y;
			mz_s1 <= in_z * scale.z;
		end
	end

	// round half up, drop 12 fraction bits
	always_comb begin
		rx = mx_s1 + 48'sd2048;
		ry = my_s1 + 48'sd2048;
		rz = mz_s1 + 48'sd2048;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			d_s2.op <= op_s1;
			d_s2.x  <= $signed(rx[47:12]);
			d_s2.y  <= $signed(ry[47:12]);
			d_s2.z  <= $signed(rz[47:12]);
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

### src/qstp_rotate.sv
// Rotation stages: c = round(q x p), then r30 = p*2^14 + 2*(w*c + q x c).
// Depends on qstp_pkg.
module qstp_rotate
	import qstp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  scaled_t in_data,
	input  quat_t   quat,
	output logic    out_valid,
	input  logic    out_ready,
	output rot_t    out_data
);

	logic    v_s3, v_s4, v_s5, v_s6;
	logic    en3, en4, en5, en6;
	scaled_t p_s3, p_s4, p_s5;
	prod52_t ax_s3, bx_s3, ay_s3, by_s3, az_s3, bz_s3;
	cval_t   cx_s4, cy_s4, cz_s4;
	prod55_t ex_s5, fx_s5, ey_s5, fy_s5, ez_s5, fz_s5;
	prod55_t wx_s5, wy_s5, wz_s5;
	rot_t    r_s6;

	logic signed [52:0] dfx, dfy, dfz;
	logic signed [55:0] dx, dy, dz;
	logic signed [56:0] sx, sy, sz;

	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign in_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= in_valid;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// s3: partial products of q x p
	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			p_s3  <= in_data;
			ax_s3 <= quat.y * in_data.z;
			bx_s3 <= quat.z * in_data.y;
			ay_s3 <= quat.z * in_data.x;
			by_s3 <= quat.x * in_data.z;
			az_s3 <= quat.x * in_data.y;
			bz_s3 <= quat.y * in_data.x;
		end
	end

	// s4: difference, round away 14 bits
	always_comb begin
		dfx = 53'(ax_s3) - 53'(bx_s3) + 53'sd8192;
		dfy = 53'(ay_s3) - 53'(by_s3) + 53'sd8192;
		dfz = 53'(az_s3) - 53'(bz_s3) + 53'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			p_s4  <= p_s3;
			cx_s4 <= $signed(dfx[52:14]);
			cy_s4 <= $signed(dfy[52:14]);
			cz_s4 <= $signed(dfz[52:14]);
		end
	end

	// s5: partial products of q x c and w * c
	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			p_s5  <= p_s4;
			ex_s5 <= quat.y * cz_s4;
			fx_s5 <= quat.z * cy_s4;
			ey_s5 <= quat.z * cx_s4;
			fy_s5 <= quat.x * cz_s4;
			ez_s5 <= quat.x * cy_s4;
			fz_s5 <= quat.y * cx_s4;
			wx_s5 <= quat.w * cx_s4;
			wy_s5 <= quat.w * cy_s4;
			wz_s5 <= quat.w * cz_s4;
		end
	end

	// s6: exact Q.30 sum, half LSB folded in for the final round
	always_comb begin
		dx = 56'(ex_s5) - 56'(fx_s5);
		dy = 56'(ey_s5) - 56'(fy_s5);
		dz = 56'(ez_s5) - 56'(fz_s5);
		sx = 57'(wx_s5) + 57'(dx);
		sy = 57'(wy_s5) + 57'(dy);
		sz = 57'(wz_s5) + 57'(dz);
	end

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			r_s6.op <= p_s5.op;
			r_s6.x  <= 59'($signed({p_s5.x, 14'b0})) + 59'($signed({sx, 1'b0}))
				+ 59'sd8192;
			r_s6.y  <= 59'($signed({p_s5.y, 14'b0})) + 59'($signed({sy, 1'b0}))
				+ 59'sd8192;
			r_s6.z  <= 59'($signed({p_s5.z, 14'b0})) + 59'($signed({sz, 1'b0}))
				+ 59'sd8192;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = r_s6;

endmodule

### src/qstp_out.sv
// Output stage: drop 14 fraction bits of the Q.30 sum to Q16.16, add translation for points, saturate.
// Depends on qstp_pkg; holds the output register of the block.
module qstp_out
	import qstp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  rot_t   in_data,
	input  shift_t shift,
	output logic   out_valid,
	input  logic   out_ready,
	output coord_t out_x,
	output coord_t out_y,
	output coord_t out_z,
	output logic   out_clipped
);

	logic   v_s7, en7;
	coord_t tx, ty, tz;
	logic signed [45:0] ux, uy, uz;
	coord_t ox, oy, oz;
	logic   kx, ky, kz;
	coord_t x_s7, y_s7, z_s7;
	logic   clip_s7;

	assign en7      = !v_s7 || out_ready;
	assign in_ready = en7;

	always_comb begin
		tx = in_data.op ? shift.x : '0;
		ty = in_data.op ? shift.y : '0;
		tz = in_data.op ? shift.z : '0;
		ux = 46'($signed(in_data.x[58:14])) + 46'(tx);
		uy = 46'($signed(in_data.y[58:14])) + 46'(ty);
		uz = 46'($signed(in_data.z[58:14])) + 46'(tz);

		kx = 1'b1;
		if (ux > SAT_HI) begin
			ox = 32'sh7fffffff;
		end else if (ux < SAT_LO) begin
			ox = 32'sh80000000;
		end else begin
			ox = ux[31:0];
			kx = 1'b0;
		end

		ky = 1'b1;
		if (uy > SAT_HI) begin
			oy = 32'sh7fffffff;
		end else if (uy < SAT_LO) begin
			oy = 32'sh80000000;
		end else begin
			oy = uy[31:0];
			ky = 1'b0;
		end

		kz = 1'b1;
		if (uz > SAT_HI) begin
			oz = 32'sh7fffffff;
		end else if (uz < SAT_LO) begin
			oz = 32'sh80000000;
		end else begin
			oz = uz[31:0];
			kz = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en7) begin
			v_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en7 && in_valid) begin
			x_s7    <= ox;
			y_s7    <= oy;
			z_s7    <= oz;
			clip_s7 <= kx | ky | kz;
		end
	end

	assign out_valid   = v_s7;
	assign out_x       = x_s7;
	assign out_y       = y_s7;
	assign out_z       = z_s7;
	assign out_clipped = clip_s7;

endmodule

### src/qstp_checker.sv
// Port-level checker for quat_scale_translate_point, bound to the top level.
// Depends on qstp_pkg and quat_scale_translate_point_defines.svh.
`include "quat_scale_translate_point_defines.svh"

module qstp_checker
	import qstp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [95:0]      m_axis_tdata,  // out_x, out_y, out_z from bit 0 up
	input logic             m_axis_tuser   // clipped
);

	logic             acc, dlv;
	logic [CNT_W-1:0] inflight_q;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign dlv = m_axis_tvalid && m_axis_tready;

	// words accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({acc, dlv})
				2'b10:   inflight_q <= inflight_q + CNT_W'(1);
				2'b01:   inflight_q <= inflight_q - CNT_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	`QSTP_ASSERT_NXT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word withdrawn while stalled")
	`QSTP_ASSERT_NXT(a_out_word_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
	`QSTP_ASSERT_IMP(a_no_extra_word, m_axis_tvalid, inflight_q != '0, "output word with nothing in flight")
	`QSTP_ASSERT_IMP(a_empty_accepts, inflight_q == '0, s_axis_tready, "empty pipeline refuses input")
	`QSTP_ASSERT_IMP(a_full_stalls, (inflight_q == CNT_W'(PIPE_DEPTH)) && !m_axis_tready, !s_axis_tready, "full pipeline still accepts input")

endmodule

bind quat_scale_translate_point qstp_checker u_qstp_checker (.*);
